>>> hdl/acsm_pkg.sv
// Shared types and constants of the Aho-Corasick stream matcher.
// Used by acsm_ctrl and aho_corasick_stream_matcher; no dependencies.
package acsm_pkg;

    localparam int CMD_W   = 2;
    localparam int SYM_W   = 8;
    localparam int STATE_W = 12;
    localparam int ID_W    = 14;
    localparam int LEN_W   = 7;
    localparam int POS_W   = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_GOTO = 2'd0,
        CMD_LOAD_INFO = 2'd1,
        CMD_SCAN      = 2'd2,
        CMD_RESTART   = 2'd3
    } t_cmd;

    // One result as it leaves the block.
    typedef struct packed {
        logic               found;
        logic [ID_W-1:0]    id;
        logic [POS_W-1:0]   start;
        logic [STATE_W-1:0] state;
        logic               last;
    } t_result;

    // Table RAM strobes from the controller.
    typedef struct packed {
        logic goto_we;
        logic goto_re;
        logic info_we;
        logic info_re;
    } t_mem_ctl;

endpackage

>>> hdl/acsm_ram.sv
// Generic single-port synchronous RAM, registered read.
// No dependencies.
module acsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/acsm_ctrl.sv
// Sequencer of the matcher: table loads, goto/failure walk, output-chain walk.
// Depends on acsm_pkg; drives the goto and state-info RAMs in the top level.
module acsm_ctrl
    import acsm_pkg::*;
#(
    parameter int NUM_STATES = 4096,
    parameter int ALPHABET   = 256,
    parameter int MAX_DEPTH  = 64,
    localparam int ST = (NUM_STATES < (1 << STATE_W)) ? NUM_STATES : (1 << STATE_W),
    localparam int SW = $clog2(ST),
    localparam int CW = $clog2(ALPHABET),
    localparam int IW = SW + ID_W + LEN_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [STATE_W-1:0] i_state_index,
    input  logic [SYM_W-1:0]   i_symbol,
    input  logic               i_edge_present,
    input  logic [STATE_W-1:0] i_goto_target,
    input  logic [STATE_W-1:0] i_fail_target,
    input  logic [ID_W-1:0]    i_pattern_id,
    input  logic [LEN_W-1:0]   i_pattern_length,
    input  logic [POS_W-1:0]   i_start_position,
    output t_mem_ctl           o_mem,
    output logic [SW+CW-1:0]   o_goto_addr,
    output logic [SW:0]        o_goto_wdata,
    input  logic [SW:0]        i_goto_rdata,
    output logic [SW-1:0]      o_info_addr,
    output logic [IW-1:0]      o_info_wdata,
    input  logic [IW-1:0]      i_info_rdata,
    output logic               o_push,
    output t_result            o_result,
    input  logic               i_push_ok
);

    // Reciprocal constants for the mod-by-constant folds.
    localparam int FOLD_SH = STATE_W + SW;
    localparam int FOLD_M  = ((1 << FOLD_SH) + ST - 1) / ST;
    localparam int FM_W    = STATE_W + 2;
    localparam int PROD_W  = STATE_W + FM_W;
    localparam int SYM_SH  = SYM_W + CW;
    localparam int SYM_M   = ((1 << SYM_SH) + ALPHABET - 1) / ALPHABET;
    localparam int SM_W    = SYM_W + 2;
    localparam int SPROD_W = SYM_W + SM_W;
    localparam int DW      = $clog2(MAX_DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_SYM   = 6'b000100,
        S_WALK  = 6'b001000,
        S_CHAIN = 6'b010000,
        S_FLUSH = 6'b100000
    } t_fsm;

    t_fsm               r_fsm, n_fsm;
    logic [SW-1:0]      r_state, n_state;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic               r_pend_v, n_pend_v;
    logic [ID_W-1:0]    r_pend_id, n_pend_id;
    logic [POS_W-1:0]   r_pend_start, n_pend_start;
    t_cmd               r_cmd, n_cmd;
    logic [STATE_W-1:0] r_idx, n_idx;
    logic [STATE_W-1:0] r_qi, n_qi;
    logic [STATE_W-1:0] r_tgt, n_tgt;
    logic [STATE_W-1:0] r_qt, n_qt;
    logic [SYM_W-1:0]   r_sym, n_sym;
    logic [SYM_W-1:0]   r_q8, n_q8;
    logic               r_edge, n_edge;
    logic [ID_W-1:0]    r_id, n_id;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [CW-1:0]      r_c, n_c;
    logic [SW-1:0]      r_s, n_s;
    logic [DW-1:0]      r_steps, n_steps;
    logic [DW-1:0]      r_walked, n_walked;

    logic [STATE_W-1:0] w_tgt_in;
    logic [PROD_W-1:0]  w_qi_prod, w_qt_prod;
    logic [SPROD_W-1:0] w_sq_prod;
    logic [SW-1:0]      w_idx_fold, w_tgt_fold;
    logic [CW-1:0]      w_c;
    logic               w_sym_ok;
    logic [SW-1:0]      w_fail, w_goto_tgt, w_walk_s;
    logic [ID_W-1:0]    w_id;
    logic [LEN_W-1:0]   w_len;
    logic               w_match;
    logic [DW-1:0]      w_walked_nx;
    logic               w_chain_done;

    assign o_stall = (r_fsm != S_IDLE);

    // Quotient stage on the request fields, remainder stage on the registered quotients.
    assign w_tgt_in  = (t_cmd'(i_command) == CMD_LOAD_GOTO) ? i_goto_target : i_fail_target;
    assign w_qi_prod = PROD_W'(i_state_index) * PROD_W'(FOLD_M);
    assign w_qt_prod = PROD_W'(w_tgt_in) * PROD_W'(FOLD_M);
    assign w_sq_prod = SPROD_W'(i_symbol) * SPROD_W'(SYM_M);

    assign w_idx_fold = SW'(PROD_W'(r_idx) - PROD_W'(r_qi) * PROD_W'(ST));
    assign w_tgt_fold = SW'(PROD_W'(r_tgt) - PROD_W'(r_qt) * PROD_W'(ST));
    assign w_c        = CW'(SPROD_W'(r_sym) - SPROD_W'(r_q8) * SPROD_W'(ALPHABET));
    assign w_sym_ok   = (SPROD_W'(r_sym) < SPROD_W'(ALPHABET));

    // State-info word: {failure link, pattern id, pattern length}.
    assign w_fail     = i_info_rdata[IW-1 -: SW];
    assign w_id       = i_info_rdata[LEN_W +: ID_W];
    assign w_len      = i_info_rdata[LEN_W-1:0];
    assign w_goto_tgt = i_goto_rdata[SW-1:0];
    assign w_walk_s   = (r_steps >= DW'(MAX_DEPTH)) ? '0 : w_fail;

    assign w_match      = (w_id != '0);
    assign w_walked_nx  = r_walked + DW'(1);
    assign w_chain_done = (w_fail == '0) || (w_walked_nx >= DW'(MAX_DEPTH));

    always_comb begin
        n_fsm        = r_fsm;
        n_state      = r_state;
        n_pos        = r_pos;
        n_pend_v     = r_pend_v;
        n_pend_id    = r_pend_id;
        n_pend_start = r_pend_start;
        n_cmd        = r_cmd;
        n_idx        = r_idx;
        n_qi         = r_qi;
        n_tgt        = r_tgt;
        n_qt         = r_qt;
        n_sym        = r_sym;
        n_q8         = r_q8;
        n_edge       = r_edge;
        n_id         = r_id;
        n_len        = r_len;
        n_c          = r_c;
        n_s          = r_s;
        n_steps      = r_steps;
        n_walked     = r_walked;

        o_mem        = '0;
        o_goto_addr  = {r_s, r_c};
        o_goto_wdata = {r_edge, w_tgt_fold};
        o_info_addr  = r_s;
        o_info_wdata = {w_tgt_fold, r_id, r_len};
        o_push       = 1'b0;
        o_result     = '0;

        case (r_fsm)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd  = t_cmd'(i_command);
                    n_idx  = i_state_index;
                    n_qi   = STATE_W'(w_qi_prod >> FOLD_SH);
                    n_tgt  = w_tgt_in;
                    n_qt   = STATE_W'(w_qt_prod >> FOLD_SH);
                    n_sym  = i_symbol;
                    n_q8   = SYM_W'(w_sq_prod >> SYM_SH);
                    n_edge = i_edge_present;
                    n_id   = i_pattern_id;
                    n_len  = i_pattern_length;
                    case (t_cmd'(i_command))
                        CMD_LOAD_GOTO: n_fsm = S_LOAD;
                        CMD_LOAD_INFO: n_fsm = S_LOAD;
                        CMD_SCAN:      n_fsm = S_SYM;
                        CMD_RESTART: begin
                            n_state = '0;
                            n_pos   = i_start_position;
                        end
                        default: ;
                    endcase
                end
            end
            S_LOAD: begin
                // goto loads of a symbol outside the alphabet are dropped
                o_mem.goto_we = (r_cmd == CMD_LOAD_GOTO) && w_sym_ok;
                o_mem.info_we = (r_cmd == CMD_LOAD_INFO);
                o_goto_addr   = {w_idx_fold, r_sym[CW-1:0]};
                o_info_addr   = w_idx_fold;
                n_fsm         = S_IDLE;
            end
            S_SYM: begin
                o_mem.goto_re = 1'b1;
                o_mem.info_re = 1'b1;
                o_goto_addr   = {r_state, w_c};
                o_info_addr   = r_state;
                n_c           = w_c;
                n_s           = r_state;
                n_steps       = '0;
                n_pend_v      = 1'b0;
                n_fsm         = S_WALK;
            end
            S_WALK: begin
                n_walked = '0;
                if (i_goto_rdata[SW]) begin
                    n_state = w_goto_tgt;
                    if (w_goto_tgt == '0) begin
                        n_fsm = S_FLUSH;
                    end else begin
                        o_mem.info_re = 1'b1;
                        o_info_addr   = w_goto_tgt;
                        n_fsm         = S_CHAIN;
                    end
                end else if (r_s == '0) begin
                    n_state = '0;
                    n_fsm   = S_FLUSH;
                end else begin
                    // follow the failure link, or jump to root once the walk runs too long
                    if (r_steps < DW'(MAX_DEPTH)) begin
                        n_steps = r_steps + DW'(1);
                    end
                    n_s           = w_walk_s;
                    o_mem.goto_re = 1'b1;
                    o_mem.info_re = 1'b1;
                    o_goto_addr   = {w_walk_s, r_c};
                    o_info_addr   = w_walk_s;
                end
            end
            S_CHAIN: begin
                // a held match goes out as not last when a newer one arrives, else as last in S_FLUSH
                if (!(w_match && r_pend_v && !i_push_ok)) begin
                    if (w_match && r_pend_v) begin
                        o_push   = 1'b1;
                        o_result = '{found: 1'b1, id: r_pend_id, start: r_pend_start,
                                     state: STATE_W'(r_state), last: 1'b0};
                    end
                    if (w_match) begin
                        n_pend_v     = 1'b1;
                        n_pend_id    = w_id;
                        n_pend_start = r_pos + POS_W'(1) - POS_W'(w_len);
                    end
                    n_walked = w_walked_nx;
                    if (w_chain_done) begin
                        n_fsm = S_FLUSH;
                    end else begin
                        o_mem.info_re = 1'b1;
                        o_info_addr   = w_fail;
                    end
                end
            end
            S_FLUSH: begin
                if (i_push_ok) begin
                    o_push   = 1'b1;
                    o_result = '{found: r_pend_v,
                                 id:    r_pend_v ? r_pend_id : '0,
                                 start: r_pend_v ? r_pend_start : '0,
                                 state: STATE_W'(r_state),
                                 last:  1'b1};
                    n_pos    = r_pos + POS_W'(1);
                    n_fsm    = S_IDLE;
                end
            end
            default: n_fsm = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm    <= S_IDLE;
            r_state  <= '0;
            r_pos    <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_fsm    <= n_fsm;
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_id    <= n_pend_id;
        r_pend_start <= n_pend_start;
        r_cmd        <= n_cmd;
        r_idx        <= n_idx;
        r_qi         <= n_qi;
        r_tgt        <= n_tgt;
        r_qt         <= n_qt;
        r_sym        <= n_sym;
        r_q8         <= n_q8;
        r_edge       <= n_edge;
        r_id         <= n_id;
        r_len        <= n_len;
        r_c          <= n_c;
        r_s          <= n_s;
        r_steps      <= n_steps;
        r_walked     <= n_walked;
    end

endmodule

>>> hdl/aho_corasick_stream_matcher.sv
// Aho-Corasick stream matcher: goto RAM, state-info RAM, sequencer, output register.
// A scan request follows failure links until a goto edge is found, then walks the new
// state's output chain, where each non-root state costs one state-info RAM read.
// o_stall holds off new requests until the sequencer is idle; result-side stalls hold it.
// Reset (synchronous, active low): root state, position 0, no result pending; table RAMs
// are not cleared and must be loaded before scanning. Depends on acsm_pkg, acsm_ram, acsm_ctrl.
module aho_corasick_stream_matcher
    import acsm_pkg::*;
#(
    parameter int NUM_STATES = 4096,
    parameter int ALPHABET   = 256,
    parameter int MAX_DEPTH  = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [STATE_W-1:0] i_state_index,
    input  logic [SYM_W-1:0]   i_symbol,
    input  logic               i_edge_present,
    input  logic [STATE_W-1:0] i_goto_target,
    input  logic [STATE_W-1:0] i_fail_target,
    input  logic [ID_W-1:0]    i_pattern_id,
    input  logic [LEN_W-1:0]   i_pattern_length,
    input  logic [POS_W-1:0]   i_start_position,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_match_found,
    output logic [ID_W-1:0]    o_matched_id,
    output logic [POS_W-1:0]   o_match_start,
    output logic [STATE_W-1:0] o_current_state,
    output logic               o_last
);

    // States above the 12-bit field range are unreachable, so the tables stop there.
    localparam int ST = (NUM_STATES < (1 << STATE_W)) ? NUM_STATES : (1 << STATE_W);
    localparam int SW = $clog2(ST);
    localparam int CW = $clog2(ALPHABET);
    localparam int IW = SW + ID_W + LEN_W;

    t_mem_ctl         w_mem;
    logic [SW+CW-1:0] w_goto_addr;
    logic [SW:0]      w_goto_wdata, w_goto_rdata;
    logic [SW-1:0]    w_info_addr;
    logic [IW-1:0]    w_info_wdata, w_info_rdata;
    logic             w_push;
    logic             w_push_ok;
    t_result          w_result;

    logic             r_valid;
    t_result          r_result;

    // Goto table: one row per state, one entry per symbol, {edge, target}.
    acsm_ram #(
        .WIDTH (SW + 1),
        .DEPTH (ST * (1 << CW))
    ) u_goto_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.goto_we),
        .i_re    (w_mem.goto_re),
        .i_addr  (w_goto_addr),
        .i_wdata (w_goto_wdata),
        .o_rdata (w_goto_rdata)
    );

    // State info: failure link, pattern id and pattern length of each state.
    acsm_ram #(
        .WIDTH (IW),
        .DEPTH (ST)
    ) u_info_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.info_we),
        .i_re    (w_mem.info_re),
        .i_addr  (w_info_addr),
        .i_wdata (w_info_wdata),
        .o_rdata (w_info_rdata)
    );

    acsm_ctrl #(
        .NUM_STATES (NUM_STATES),
        .ALPHABET   (ALPHABET),
        .MAX_DEPTH  (MAX_DEPTH)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_command        (i_command),
        .i_state_index    (i_state_index),
        .i_symbol         (i_symbol),
        .i_edge_present   (i_edge_present),
        .i_goto_target    (i_goto_target),
        .i_fail_target    (i_fail_target),
        .i_pattern_id     (i_pattern_id),
        .i_pattern_length (i_pattern_length),
        .i_start_position (i_start_position),
        .o_mem            (w_mem),
        .o_goto_addr      (w_goto_addr),
        .o_goto_wdata     (w_goto_wdata),
        .i_goto_rdata     (w_goto_rdata),
        .o_info_addr      (w_info_addr),
        .o_info_wdata     (w_info_wdata),
        .i_info_rdata     (w_info_rdata),
        .o_push           (w_push),
        .o_result         (w_result),
        .i_push_ok        (w_push_ok)
    );

    // Output register: takes a new result when empty or being drained this cycle,
    // so the sequencer keeps walking while a finished result waits downstream and stalls only to push.
    assign w_push_ok = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_push) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_result <= w_result;
        end
    end

    assign o_valid         = r_valid;
    assign o_match_found   = r_result.found;
    assign o_matched_id    = r_result.id;
    assign o_match_start   = r_result.start;
    assign o_current_state = r_result.state;
    assign o_last          = r_result.last;

endmodule
